// ===== src/tsrl_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tsrl_pkg: shared types and constants
// Field widths, status codes, granularity codes and the timestamp mask.
// ----------------------------------------------------------------------------
package tsrl_pkg;

  localparam int CAPACITY = 64;
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int ADDR_W   = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;

  localparam int ID_W     = 31;
  localparam int TIME_W   = 49;
  localparam int GRAN_W   = 3;
  localparam int STATUS_W = 2;
  localparam int REC_W    = ID_W + TIME_W;

  // lowest bit kept for each granularity
  localparam int LOW_YEAR   = 35;
  localparam int LOW_MONTH  = 28;
  localparam int LOW_DAY    = 21;
  localparam int LOW_HOUR   = 14;
  localparam int LOW_MINUTE = 7;
  localparam int LOW_SECOND = 0;

  localparam logic [GRAN_W-1:0] GRAN_YEAR   = 3'd0;
  localparam logic [GRAN_W-1:0] GRAN_MONTH  = 3'd1;
  localparam logic [GRAN_W-1:0] GRAN_DAY    = 3'd2;
  localparam logic [GRAN_W-1:0] GRAN_HOUR   = 3'd3;
  localparam logic [GRAN_W-1:0] GRAN_MINUTE = 3'd4;

  typedef enum logic {
    FUNC_PUT = 1'b0,
    FUNC_GET = 1'b1
  } func_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_STORED  = 2'd0,
    ST_FULL    = 2'd1,
    ST_MATCH   = 2'd2,
    ST_NOMATCH = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_PUT,
    S_SCAN,
    S_FLUSH
  } state_t;

  // Mask that clears every field finer than the granularity.
  // Codes beyond second keep the whole timestamp.
  function automatic logic [TIME_W-1:0] trunc_mask(input logic [GRAN_W-1:0] gran);
    logic [5:0] sh;
    case (gran)
      GRAN_YEAR:   sh = 6'(LOW_YEAR);
      GRAN_MONTH:  sh = 6'(LOW_MONTH);
      GRAN_DAY:    sh = 6'(LOW_DAY);
      GRAN_HOUR:   sh = 6'(LOW_HOUR);
      GRAN_MINUTE: sh = 6'(LOW_MINUTE);
      default:     sh = 6'(LOW_SECOND);
    endcase
    return ~((TIME_W'(1) << sh) - TIME_W'(1));
  endfunction

endpackage

// ===== src/tsrl_in_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tsrl_in_if: request channel
// Valid/ready channel carrying one put or retrieve word.
// ----------------------------------------------------------------------------
interface tsrl_in_if import tsrl_pkg::*; ();
  logic              valid;
  logic              ready;
  logic              func;
  logic [ID_W-1:0]   record_id;
  logic [TIME_W-1:0] time_a;
  logic [TIME_W-1:0] time_b;
  logic [GRAN_W-1:0] granularity;

  modport source (output valid, func, record_id, time_a, time_b, granularity,
                  input ready);
  modport sink   (input valid, func, record_id, time_a, time_b, granularity,
                  output ready);
endinterface

// ===== src/tsrl_out_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tsrl_out_if: result channel
// Valid/ready channel carrying one result word.
// ----------------------------------------------------------------------------
interface tsrl_out_if import tsrl_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [STATUS_W-1:0] status;
  logic [ID_W-1:0]     match_id;
  logic                last;

  modport source (output valid, status, match_id, last, input ready);
  modport sink   (input valid, status, match_id, last, output ready);
endinterface

// ===== src/tsrl_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tsrl_ram: generic simple dual-port RAM
// One write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module tsrl_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== src/timestamp_range_log_store.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// timestamp_range_log_store: log record store with time range retrieve
// Appends id/timestamp records and scans them for a truncated time range.
// ----------------------------------------------------------------------------
// Put: the request passes through S_PUT, where the result word is loaded into the
//   output register once it is free; the next word is taken after that load.
// Retrieve: one stored record compared per cycle, unless a match waits on a stalled
//   result side, by a single range comparator fed from the record RAM read port;
//   every stored record, up to CAPACITY, is scanned before S_FLUSH issues the last word.
// One request word is in flight at a time.
// Reset clears the record count, sequencer and output valid; RAM is not cleared.
module timestamp_range_log_store import tsrl_pkg::*; (
  input  logic         clk,
  input  logic         rst_n,
  tsrl_in_if.sink      in_ch,
  tsrl_out_if.source   out_ch
);

  state_t state_r, state_nxt;

  // record count and scan pointer (pointer addresses the RAM output word)
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic [CNT_W-1:0]  idx_r, idx_nxt;

  // range bounds, already truncated, and the mask for stored times
  logic [TIME_W-1:0] mask_r, lo_r, hi_r;
  logic [TIME_W-1:0] in_mask;
  logic              put_full_r;

  // pending match: held back until we know whether it is the last one
  logic              pend_r, pend_nxt;
  logic [ID_W-1:0]   pend_id_r, pend_id_nxt;

  // output register
  logic                out_valid_r, out_valid_nxt;
  logic [STATUS_W-1:0] out_status_r, out_status_nxt;
  logic [ID_W-1:0]     out_id_r, out_id_nxt;
  logic                out_last_r, out_last_nxt;
  logic                out_free;

  logic              in_acc;
  logic              is_full;
  logic              ram_we;
  logic [REC_W-1:0]  ram_rdata;
  logic [ID_W-1:0]   rec_id;
  logic [TIME_W-1:0] rec_time;
  logic [TIME_W-1:0] rec_trunc;
  logic              hit;
  logic              step;
  logic              last_rec;

  assign in_ch.ready = (state_r == S_IDLE);
  assign in_acc      = in_ch.valid && in_ch.ready;
  assign is_full     = (cnt_r == CNT_W'(CAPACITY));
  assign out_free    = !out_valid_r || out_ch.ready;
  assign in_mask     = trunc_mask(in_ch.granularity);

  assign ram_we = in_acc && (in_ch.func == FUNC_PUT) && !is_full;

  tsrl_ram #(
    .WIDTH (REC_W),
    .DEPTH (CAPACITY)
  ) u_rec_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (cnt_r[ADDR_W-1:0]),
    .wdata ({in_ch.record_id, in_ch.time_a}),
    .raddr (idx_nxt[ADDR_W-1:0]),
    .rdata (ram_rdata)
  );

  assign rec_id    = ram_rdata[REC_W-1:TIME_W];
  assign rec_time  = ram_rdata[TIME_W-1:0];

  // the shared range comparator
  assign rec_trunc = rec_time & mask_r;
  assign hit       = (rec_trunc >= lo_r) && (rec_trunc <= hi_r);

  // a second match can only advance once the pending one has gone out
  assign step      = !(hit && pend_r && !out_free);
  assign last_rec  = ((idx_r + CNT_W'(1)) == cnt_r);

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          if (in_ch.func == FUNC_PUT) begin
            state_nxt = S_PUT;
          end else if (cnt_r == '0) begin
            state_nxt = S_FLUSH;
          end else begin
            state_nxt = S_SCAN;
          end
        end
      end
      S_PUT: begin
        if (out_free) begin
          state_nxt = S_IDLE;
        end
      end
      S_SCAN: begin
        if (step && last_rec) begin
          state_nxt = S_FLUSH;
        end
      end
      S_FLUSH: begin
        if (out_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // datapath and output word
  always_comb begin
    cnt_nxt        = cnt_r;
    idx_nxt        = '0;
    pend_nxt       = pend_r;
    pend_id_nxt    = pend_id_r;
    out_valid_nxt  = out_valid_r && !out_ch.ready;
    out_status_nxt = out_status_r;
    out_id_nxt     = out_id_r;
    out_last_nxt   = out_last_r;
    if (ram_we) begin
      cnt_nxt = cnt_r + CNT_W'(1);
    end
    case (state_r)
      S_PUT: begin
        if (out_free) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = put_full_r ? ST_FULL : ST_STORED;
          out_id_nxt     = '0;
          out_last_nxt   = 1'b1;
        end
      end
      S_SCAN: begin
        idx_nxt = step ? idx_r + CNT_W'(1) : idx_r;
        if (hit && step) begin
          if (pend_r) begin
            // an earlier match exists, so that one is not the last
            out_valid_nxt  = 1'b1;
            out_status_nxt = ST_MATCH;
            out_id_nxt     = pend_id_r;
            out_last_nxt   = 1'b0;
          end
          pend_nxt    = 1'b1;
          pend_id_nxt = rec_id;
        end
      end
      S_FLUSH: begin
        if (out_free) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = pend_r ? ST_MATCH : ST_NOMATCH;
          out_id_nxt     = pend_r ? pend_id_r : '0;
          out_last_nxt   = 1'b1;
          pend_nxt       = 1'b0;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      idx_r       <= '0;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      idx_r       <= idx_nxt;
      pend_r      <= pend_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pend_id_r    <= pend_id_nxt;
    out_status_r <= out_status_nxt;
    out_id_r     <= out_id_nxt;
    out_last_r   <= out_last_nxt;
    if (in_acc) begin
      put_full_r <= is_full;
      mask_r     <= in_mask;
      lo_r       <= in_ch.time_a & in_mask;
      hi_r       <= in_ch.time_b & in_mask;
    end
  end

  assign out_ch.valid    = out_valid_r;
  assign out_ch.status   = out_status_r;
  assign out_ch.match_id = out_id_r;
  assign out_ch.last     = out_last_r;

  // checks
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_W'(CAPACITY))
    else $error("record count beyond capacity");

  a_pend_scope: assert property (@(posedge clk) disable iff (!rst_n)
    pend_r |-> (state_r == S_SCAN || state_r == S_FLUSH))
    else $error("pending match outside a retrieve");

  a_scan_ptr: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SCAN) |-> (idx_r < cnt_r))
    else $error("scan pointer past stored records");

  a_scan_cnt: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SCAN) |=> $stable(cnt_r))
    else $error("record count changed during scan");

  a_flush_done: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_FLUSH && out_free) |=> (state_r == S_IDLE && out_valid_r && out_last_r))
    else $error("final word not issued on flush");

endmodule

// ===== dv/tsrl_result_check.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tsrl_result_check: result checker for the log record store
// Watches both channels, keeps a shadow copy of the record store, works out
// the result words each accepted request causes, and compares them in order.
// ----------------------------------------------------------------------------
module tsrl_result_check import tsrl_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  tsrl_in_if          in_mon,
  tsrl_out_if         out_mon,
  output int unsigned fail_count,
  output int unsigned due_count
);

  typedef struct {
    status_t         status;
    logic [ID_W-1:0] id;
    logic            last;
  } reply_t;

  reply_t              due_replies[$];
  logic [ID_W-1:0]     shadow_ids   [CAPACITY];
  logic [TIME_W-1:0]   shadow_times [CAPACITY];
  int                  shadow_count;

  // clear every field finer than the granularity; codes past second keep all
  function automatic logic [TIME_W-1:0] coarsen(input logic [TIME_W-1:0] t,
                                                input logic [GRAN_W-1:0] gran);
    int sh;
    case (gran)
      GRAN_YEAR:   sh = LOW_YEAR;
      GRAN_MONTH:  sh = LOW_MONTH;
      GRAN_DAY:    sh = LOW_DAY;
      GRAN_HOUR:   sh = LOW_HOUR;
      GRAN_MINUTE: sh = LOW_MINUTE;
      default:     sh = LOW_SECOND;
    endcase
    return (t >> sh) << sh;
  endfunction

  task automatic report_mismatch(input string msg);
    fail_count++;
    $display("MISMATCH @%0t: %s", $time, msg);
  endtask

  // append a word to the tail of the due list
  task automatic queue_reply(input reply_t w);
    due_replies.insert(due_replies.size(), w);
  endtask

  task automatic log_request(input logic func, input logic [ID_W-1:0] id,
                             input logic [TIME_W-1:0] ta, input logic [TIME_W-1:0] tb,
                             input logic [GRAN_W-1:0] gran);
    reply_t            r;
    reply_t            held;
    bit                have_held;
    logic [TIME_W-1:0] lo;
    logic [TIME_W-1:0] hi;
    logic [TIME_W-1:0] t;
    have_held = 0;
    if (func == FUNC_PUT) begin
      r.id   = '0;
      r.last = 1'b1;
      if (shadow_count < CAPACITY) begin
        shadow_ids[shadow_count]   = id;
        shadow_times[shadow_count] = ta;
        shadow_count++;
        r.status = ST_STORED;
      end else begin
        r.status = ST_FULL;
      end
      queue_reply(r);
    end else begin
      lo = coarsen(ta, gran);
      hi = coarsen(tb, gran);
      for (int i = 0; i < shadow_count; i++) begin
        t = coarsen(shadow_times[i], gran);
        if (t >= lo && t <= hi) begin
          if (have_held) queue_reply(held);
          held.status = ST_MATCH;
          held.id     = shadow_ids[i];
          held.last   = 1'b0;
          have_held   = 1;
        end
      end
      if (have_held) begin
        held.last = 1'b1;
        queue_reply(held);
      end else begin
        r.status = ST_NOMATCH;
        r.id     = '0;
        r.last   = 1'b1;
        queue_reply(r);
      end
    end
  endtask

  task automatic check_reply();
    reply_t want;
    if (due_replies.size() == 0) begin
      report_mismatch($sformatf("result word with nothing due: status %0d id %0h last %0b",
                                out_mon.status, out_mon.match_id, out_mon.last));
    end else begin
      want = due_replies.pop_front();
      if (out_mon.status !== want.status || out_mon.match_id !== want.id ||
          out_mon.last !== want.last)
        report_mismatch($sformatf("got status %0d id %0h last %0b, want %0d %0h %0b",
                                  out_mon.status, out_mon.match_id, out_mon.last,
                                  want.status, want.id, want.last));
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      shadow_count = 0;
      fail_count   = 0;
      due_replies.delete();
    end else begin
      if (out_mon.valid && out_mon.ready) check_reply();
      if (in_mon.valid && in_mon.ready)
        log_request(in_mon.func, in_mon.record_id, in_mon.time_a, in_mon.time_b,
                    in_mon.granularity);
    end
    due_count <= due_replies.size();
  end

endmodule

// ===== dv/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: testbench for timestamp_range_log_store
// Drives put and retrieve words with random gaps and result back-pressure;
// the result checker beside the block predicts and compares every word.
// ----------------------------------------------------------------------------
module tb_top import tsrl_pkg::*; ();

  // granularity codes the package leaves unnamed
  localparam logic [GRAN_W-1:0] GRAN_SECOND = 3'd5;
  localparam logic [GRAN_W-1:0] GRAN_ALIAS0 = 3'd6;  // both treated as second
  localparam logic [GRAN_W-1:0] GRAN_ALIAS1 = 3'd7;

  localparam int RANDOM_WORDS = 110;
  localparam int IDLE_PCT     = 8;

  logic        clk = 1'b0;
  logic        rst_n;
  int unsigned fail_count;
  int unsigned due_count;
  logic        calm_sink;   // no back-pressure while set
  int          puts_sent;

  tsrl_in_if  in_ch ();
  tsrl_out_if out_ch ();

  timestamp_range_log_store u_top (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  tsrl_result_check u_result_check (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_mon     (in_ch),
    .out_mon    (out_ch),
    .fail_count (fail_count),
    .due_count  (due_count)
  );

  always #5 clk = ~clk;

  // hard stop well beyond the slowest legal run
  initial begin
    #2_000_000;
    $display("Some tests failed");
    $finish;
  end

  // result side: stalls about 8 percent of the time, none while calm_sink is set
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= calm_sink || ($urandom_range(0, 99) >= IDLE_PCT);
    end
  end

  // timestamp packing: year 14 bits, then month, day, hour, minute, second
  function automatic logic [TIME_W-1:0] pack_time(input int y, input int mo, input int d,
                                                  input int h, input int mi, input int s);
    return {14'(y), 7'(mo), 7'(d), 7'(h), 7'(mi), 7'(s)};
  endfunction

  function automatic logic [TIME_W-1:0] any_time();
    return TIME_W'({$urandom(), $urandom()});
  endfunction

  // narrow calendar pool so that ranges hit often at every granularity;
  // the odd fully random value keeps every bit moving
  function automatic logic [TIME_W-1:0] pick_time();
    if ($urandom_range(0, 99) < 12) return any_time();
    return pack_time(2020 + $urandom_range(0, 2), $urandom_range(1, 3),
                     $urandom_range(1, 3), $urandom_range(0, 2),
                     $urandom_range(0, 2), $urandom_range(0, 2));
  endfunction

  function automatic logic [GRAN_W-1:0] pick_gran();
    if ($urandom_range(0, 99) < 10) return ($urandom_range(0, 1) != 0) ? GRAN_ALIAS0
                                                                       : GRAN_ALIAS1;
    return GRAN_W'($urandom_range(GRAN_YEAR, GRAN_SECOND));
  endfunction

  // Present one word and hold it until the block takes it. Called just after
  // a rising edge; returns just after the accepting edge.
  task automatic send_word(input func_t f, input logic [ID_W-1:0] id,
                           input logic [TIME_W-1:0] ta, input logic [TIME_W-1:0] tb,
                           input logic [GRAN_W-1:0] gran);
    in_ch.valid       <= 1'b1;
    in_ch.func        <= f;
    in_ch.record_id   <= id;
    in_ch.time_a      <= ta;
    in_ch.time_b      <= tb;
    in_ch.granularity <= gran;
    do @(posedge clk); while (!in_ch.ready);
    if (f == FUNC_PUT) puts_sent++;
  endtask

  // random idle cycles on the request side between words
  task automatic request_gap(input bit calm);
    while (!calm && $urandom_range(0, 99) < IDLE_PCT) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
  endtask

  initial begin
    logic [TIME_W-1:0] ta;
    logic [TIME_W-1:0] tb;
    logic [TIME_W-1:0] swap;
    bit                calm;
    int                n;

    rst_n             = 1'b0;
    calm_sink         = 1'b0;
    puts_sent         = 0;
    in_ch.valid       = 1'b0;
    in_ch.func        = FUNC_PUT;
    in_ch.record_id   = '0;
    in_ch.time_a      = '0;
    in_ch.time_b      = '0;
    in_ch.granularity = GRAN_YEAR;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // ---- directed part ----
    // retrieve on an empty store: no record, so a lone no-match word
    send_word(FUNC_GET, '0, '0, '1, GRAN_YEAR);
    // field extremes and alternating bit patterns
    send_word(FUNC_PUT, '0, '0, '1, GRAN_YEAR);
    send_word(FUNC_PUT, '1, '1, '0, GRAN_ALIAS1);
    send_word(FUNC_PUT, 31'h2AAAAAAA, 49'h0AAAA_AAAA_AAAA, 49'h15555_5555_5555, GRAN_MONTH);
    send_word(FUNC_PUT, 31'h55555555, 49'h15555_5555_5555, 49'h0AAAA_AAAA_AAAA, GRAN_DAY);
    // a ladder of records, each dropping out one granularity earlier
    send_word(FUNC_PUT, 31'd100, pack_time(2021, 6, 15, 12, 30, 45), '0, GRAN_YEAR);
    send_word(FUNC_PUT, 31'd101, pack_time(2021, 6, 15, 12, 30, 10), '0, GRAN_YEAR);
    send_word(FUNC_PUT, 31'd102, pack_time(2021, 6, 15, 12, 5, 0), '0, GRAN_YEAR);
    send_word(FUNC_PUT, 31'd103, pack_time(2021, 6, 15, 3, 0, 0), '0, GRAN_YEAR);
    send_word(FUNC_PUT, 31'd104, pack_time(2021, 6, 2, 0, 0, 0), '0, GRAN_YEAR);
    send_word(FUNC_PUT, 31'd105, pack_time(2021, 1, 1, 0, 0, 0), '0, GRAN_YEAR);
    send_word(FUNC_PUT, 31'd106, pack_time(2022, 6, 15, 12, 30, 45), '0, GRAN_YEAR);
    // same window at every granularity code, aliases of second included
    ta = pack_time(2021, 6, 15, 12, 30, 20);
    tb = pack_time(2021, 6, 15, 12, 30, 50);
    for (int g = 0; g < 8; g++) send_word(FUNC_GET, '0, ta, tb, GRAN_W'(g));
    // start after end: nothing can match
    send_word(FUNC_GET, '0, '1, '0, GRAN_SECOND);
    // whole range, out-of-calendar fields included
    send_word(FUNC_GET, '1, '0, '1, GRAN_HOUR);

    // ---- random part ----
    // Puts dominate until the store has overflowed, so the full case is hit
    // and later retrieves scan the whole store. Ranges are mostly ordered
    // pairs from the pool; the rest are reversed or wild.
    n = 0;
    while (n < RANDOM_WORDS || puts_sent < CAPACITY + 4) begin
      calm = (n >= 40 && n < 75);
      calm_sink <= (n >= 60 && n < 95);
      request_gap(calm);
      if ($urandom_range(0, 99) < ((puts_sent < CAPACITY + 4) ? 70 : 30)) begin
        send_word(FUNC_PUT, ID_W'($urandom()), pick_time(), any_time(), pick_gran());
      end else begin
        ta = pick_time();
        tb = pick_time();
        if (ta > tb && $urandom_range(0, 99) < 85) begin
          swap = ta;
          ta   = tb;
          tb   = swap;
        end
        send_word(FUNC_GET, ID_W'($urandom()), ta, tb, pick_gran());
      end
      n++;
    end
    in_ch.valid <= 1'b0;
    calm_sink   <= 1'b0;

    // drain: let the last word reach the due list, wait for every due word,
    // then a full scan's worth of quiet cycles
    @(posedge clk);
    while (due_count != 0) @(posedge clk);
    repeat (CAPACITY + 8) @(posedge clk);

    if (fail_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
src/tsrl_pkg.sv
src/tsrl_in_if.sv
src/tsrl_out_if.sv
src/tsrl_ram.sv
src/timestamp_range_log_store.sv
dv/tsrl_result_check.sv
dv/tb_top.sv
